// ===== design/epg_pkg.sv =====
`default_nettype none

package epg_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_POINTS_DEF    = 4096;
   localparam int FRAC_BITS_DEF     = 8;
   localparam int CORDIC_STAGES_DEF = 16;

   // Fixed field widths.
   localparam int IDX_W     = 12;
   localparam int CNT_W     = 13;
   localparam int AXIS_W    = 18;
   localparam int ANGLE_W   = 16;
   localparam int CTR_W     = 26;
   localparam int OUT_W     = 28;
   localparam int CSR_W     = 26;
   localparam int CSR_IDX_W = 3;

   // CORDIC formats: Q30 data, 32-bit binary angle, Q24 results.
   localparam int ATAN_LEN = 24;
   localparam int TRIG_W   = 26;
   localparam int CX_W     = 33;
   localparam int CZ_W     = 34;
   localparam logic signed [CX_W-1:0] GAIN_Q30 = 33'sd652032874;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEMI_A      = 3'd0,
      CSR_SEMI_B      = 3'd1,
      CSR_ROTATION    = 3'd2,
      CSR_CENTER_X    = 3'd3,
      CSR_CENTER_Y    = 3'd4,
      CSR_POINT_COUNT = 3'd5
   } csr_index_type;

   // Valid bit and index error flag that travel with every word.
   typedef struct packed {
      logic valid;
      logic err;
   } tag_type;

   // Sine and cosine of the polygon angle and of the rotation.
   typedef struct packed {
      logic signed [TRIG_W-1:0] c;
      logic signed [TRIG_W-1:0] s;
      logic signed [TRIG_W-1:0] ca;
      logic signed [TRIG_W-1:0] sa;
   } trig_type;

   // Arctangent of 2^-k as a 32-bit binary angle.
   function automatic logic [31:0] atan_val(input int k);
      case (k)
         0:  atan_val = 32'h20000000;
         1:  atan_val = 32'h12E4051E;
         2:  atan_val = 32'h09FB385B;
         3:  atan_val = 32'h051111D4;
         4:  atan_val = 32'h028B0D43;
         5:  atan_val = 32'h0145D7E1;
         6:  atan_val = 32'h00A2F61E;
         7:  atan_val = 32'h00517C55;
         8:  atan_val = 32'h0028BE53;
         9:  atan_val = 32'h00145F2F;
         10: atan_val = 32'h000A2F98;
         11: atan_val = 32'h000517CC;
         12: atan_val = 32'h00028BE6;
         13: atan_val = 32'h000145F3;
         14: atan_val = 32'h0000A2FA;
         15: atan_val = 32'h0000517D;
         16: atan_val = 32'h000028BE;
         17: atan_val = 32'h0000145F;
         18: atan_val = 32'h00000A30;
         19: atan_val = 32'h00000518;
         20: atan_val = 32'h0000028C;
         21: atan_val = 32'h00000146;
         22: atan_val = 32'h000000A3;
         23: atan_val = 32'h00000051;
         default: atan_val = 32'h00000000;
      endcase
   endfunction

endpackage

`default_nettype wire

// ===== design/epg_cordic.sv =====
`default_nettype none

// Pipelined rotation-mode CORDIC, with registers at the input, after each stage and at the output.
module epg_cordic #(
   parameter int STAGES = epg_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                enable,
   input  wire logic [epg_pkg::ANGLE_W-1:0]         angle,
   output logic signed [epg_pkg::TRIG_W-1:0]        cos_out,
   output logic signed [epg_pkg::TRIG_W-1:0]        sin_out
);

   localparam int NST = (STAGES < epg_pkg::ATAN_LEN) ? STAGES : epg_pkg::ATAN_LEN;
   localparam int CX_W = epg_pkg::CX_W;
   localparam int CZ_W = epg_pkg::CZ_W;
   localparam int TRIG_W = epg_pkg::TRIG_W;

   logic signed [CX_W-1:0] x_ff [0:NST];
   logic signed [CX_W-1:0] y_ff [0:NST];
   logic signed [CZ_W-1:0] z_ff [0:NST];
   logic                   flip_ff [0:NST];

   logic [31:0]            raw_in;
   logic [31:0]            fold_in;
   logic                   flip_in;
   logic signed [CZ_W-1:0] z_in;

   logic signed [TRIG_W-1:0] cos_ff;
   logic signed [TRIG_W-1:0] sin_ff;

   // Round half up by six bits to Q24, then clamp to plus or minus one.
   function automatic logic signed [TRIG_W-1:0] to_q24(input logic signed [CX_W-1:0] v,
                                                       input logic neg);
      logic signed [CZ_W-1:0] w;
      logic signed [CZ_W-1:0] r;
      w = neg ? -CZ_W'(v) : CZ_W'(v);
      r = (w + 34'sd32) >>> 6;
      if (r > 34'sd16777216) begin
         to_q24 = 26'sd16777216;
      end else if (r < -34'sd16777216) begin
         to_q24 = -26'sd16777216;
      end else begin
         to_q24 = TRIG_W'(r);
      end
   endfunction

   // Angles in the second and third quadrant are turned by half a turn first.
   assign raw_in  = {angle, 16'h0000};
   assign flip_in = raw_in[31] ^ raw_in[30];
   assign fold_in = flip_in ? {~raw_in[31], raw_in[30:0]} : raw_in;
   assign z_in    = {{(CZ_W-32){fold_in[31]}}, fold_in};

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]    <= epg_pkg::GAIN_Q30;
         y_ff[0]    <= '0;
         z_ff[0]    <= z_in;
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar k = 0; k < NST; k++) begin : g_iter
      localparam logic signed [CZ_W-1:0] ATAN_K = CZ_W'(epg_pkg::atan_val(k));
      always_ff @(posedge clock) begin
         if (enable) begin
            if (!z_ff[k][CZ_W-1]) begin
               x_ff[k+1] <= x_ff[k] - (y_ff[k] >>> k);
               y_ff[k+1] <= y_ff[k] + (x_ff[k] >>> k);
               z_ff[k+1] <= z_ff[k] - ATAN_K;
            end else begin
               x_ff[k+1] <= x_ff[k] + (y_ff[k] >>> k);
               y_ff[k+1] <= y_ff[k] - (x_ff[k] >>> k);
               z_ff[k+1] <= z_ff[k] + ATAN_K;
            end
            flip_ff[k+1] <= flip_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cos_ff <= to_q24(x_ff[NST], flip_ff[NST]);
         sin_ff <= to_q24(y_ff[NST], flip_ff[NST]);
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

`default_nettype wire

// ===== design/ellipse_polygon_point_generator.sv =====
`default_nettype none

// Ellipse polygon point generator. Each word on the req_ channel carries a point index i,
// and the block answers with one word on the rsp_ channel holding point i of an n-point
// polygon that follows an ellipse with semi-axes a and b, turned by the rotation angle and
// moved to the center; coordinates are signed with FRAC_BITS fraction bits and saturate
// to 28 bits, and an index at or beyond the point count gives a zero point with
// rsp_index_error set. The block is one deep pipeline and takes a new word in every
// cycle; a stall on the result side freezes every stage at once, so nothing is dropped or
// repeated. The pipeline is made of the 16-step angle divider, the CORDIC stages, the
// 32-step square root and the radius divider, which makes one quotient bit per stage.
// Configuration must be written through the csr_ port only while no word is in flight;
// the block itself does not enforce this. A write applies to words accepted after it.
module ellipse_polygon_point_generator #(
   parameter int MAX_POINTS    = epg_pkg::MAX_POINTS_DEF,
   parameter int FRAC_BITS     = epg_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STAGES = epg_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   input  wire logic                                 csr_write_enable,
   input  wire logic [epg_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [epg_pkg::CSR_W-1:0]            csr_data,

   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [epg_pkg::IDX_W-1:0]            req_point_index,

   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [epg_pkg::OUT_W-1:0]          rsp_point_x,
   output logic signed [epg_pkg::OUT_W-1:0]          rsp_point_y,
   output logic                                      rsp_index_error,
   output logic                                      rsp_saturated
);

   localparam int AXIS_W  = epg_pkg::AXIS_W;
   localparam int CNT_W   = epg_pkg::CNT_W;
   localparam int TRIG_W  = epg_pkg::TRIG_W;
   localparam int CTR_W   = epg_pkg::CTR_W;
   localparam int OUT_W   = epg_pkg::OUT_W;
   localparam int ANGLE_W = epg_pkg::ANGLE_W;

   localparam int NST = (CORDIC_STAGES < epg_pkg::ATAN_LEN) ? CORDIC_STAGES
                                                           : epg_pkg::ATAN_LEN;
   localparam int CL  = NST + 2;          // CORDIC latency

   localparam int REM_W   = CNT_W + 1;    // angle divider remainder
   localparam int SQ_W    = 64;           // square root working width
   localparam int SQ_N    = 32;           // square root steps
   localparam int ROOT_W  = 32;
   localparam int S2_W    = 25;           // sin^2 in Q24
   localparam int RQ      = FRAC_BITS + 19;                 // radius quotient bits
   localparam int DVD_W   = 2 * AXIS_W + FRAC_BITS + 13;    // radius dividend
   localparam int DR_W    = ROOT_W + 1;
   localparam int PC_W    = RQ + TRIG_W + 1;                // r times sine or cosine
   localparam int XW      = RQ + 2;                         // point before rotation
   localparam int PW      = XW + TRIG_W;                    // rotation products
   localparam int RW      = PW + 1 - 24;                    // rotated, rounded
   localparam int SW      = ((RW > CTR_W) ? RW : CTR_W) + 2;

   localparam logic signed [SW-1:0] OUT_HI = SW'(2 ** (OUT_W - 1) - 1);
   localparam logic signed [SW-1:0] OUT_LO = SW'(-(2 ** (OUT_W - 1)));

   // ------------------------------------------------------------------
   // Configuration registers and the values derived from them.
   // ------------------------------------------------------------------
   logic [AXIS_W-1:0]        cfg_a_ff;
   logic [AXIS_W-1:0]        cfg_b_ff;
   logic [ANGLE_W-1:0]       cfg_rot_ff;
   logic signed [CTR_W-1:0]  cfg_cx_ff;
   logic signed [CTR_W-1:0]  cfg_cy_ff;
   logic [CNT_W-1:0]         cfg_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_a_ff     <= '0;
         cfg_b_ff     <= '0;
         cfg_rot_ff   <= '0;
         cfg_cx_ff    <= '0;
         cfg_cy_ff    <= '0;
         cfg_count_ff <= CNT_W'(1);
      end else if (csr_write_enable) begin
         unique case (epg_pkg::csr_index_type'(csr_index))
            epg_pkg::CSR_SEMI_A:      cfg_a_ff     <= csr_data[AXIS_W-1:0];
            epg_pkg::CSR_SEMI_B:      cfg_b_ff     <= csr_data[AXIS_W-1:0];
            epg_pkg::CSR_ROTATION:    cfg_rot_ff   <= csr_data[ANGLE_W-1:0];
            epg_pkg::CSR_CENTER_X:    cfg_cx_ff    <= csr_data[CTR_W-1:0];
            epg_pkg::CSR_CENTER_Y:    cfg_cy_ff    <= csr_data[CTR_W-1:0];
            epg_pkg::CSR_POINT_COUNT: cfg_count_ff <= csr_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // These are registered copies of values derived from the configuration; cf_dif_ff is
   // registered twice. A word accepted after a write never reaches them before they catch up.
   logic [CNT_W-1:0]    n_in;
   logic [AXIS_W-1:0]   amax_in;
   logic [AXIS_W-1:0]   bmin_in;
   logic [CNT_W-1:0]    cf_n_ff;
   logic [2*AXIS_W-1:0] cf_asq_ff;
   logic [2*AXIS_W-1:0] cf_bsq_ff;
   logic [2*AXIS_W-1:0] cf_ab_ff;
   logic [2*AXIS_W-1:0] cf_dif_ff;
   logic                cf_zero_ff;

   always_comb begin
      if (32'(cfg_count_ff) > 32'(MAX_POINTS)) begin
         n_in = CNT_W'(MAX_POINTS);
      end else begin
         n_in = cfg_count_ff;
      end
      amax_in = (cfg_a_ff > cfg_b_ff) ? cfg_a_ff : cfg_b_ff;
      bmin_in = (cfg_a_ff > cfg_b_ff) ? cfg_b_ff : cfg_a_ff;
   end

   always_ff @(posedge clock) begin
      cf_n_ff    <= n_in;
      cf_asq_ff  <= amax_in * amax_in;
      cf_bsq_ff  <= bmin_in * bmin_in;
      cf_ab_ff   <= cfg_a_ff * cfg_b_ff;
      cf_dif_ff  <= cf_asq_ff - cf_bsq_ff;
      cf_zero_ff <= (cfg_a_ff == '0) || (cfg_b_ff == '0);
   end

   // ------------------------------------------------------------------
   // Flow control: the whole pipeline moves unless a finished word is
   // held on the result side.
   // ------------------------------------------------------------------
   logic en;
   logic rsp_valid_ff;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // ------------------------------------------------------------------
   // Polygon angle: phi = floor(i * 65536 / n), one quotient bit per stage.
   // The index check at the input uses the live count, so a word accepted
   // right after a count write is judged against the new value.
   // ------------------------------------------------------------------
   epg_pkg::tag_type    dv_tag_ff [0:ANGLE_W];
   logic [REM_W-1:0]    dv_rem_ff [0:ANGLE_W];
   logic [ANGLE_W-1:0]  dv_q_ff   [0:ANGLE_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_tag_ff[0].valid <= 1'b0;
      end else if (en) begin
         dv_tag_ff[0].valid <= req_valid;
      end
      if (en) begin
         dv_tag_ff[0].err <= ({1'b0, req_point_index} >= n_in);
         dv_rem_ff[0]     <= REM_W'(req_point_index);
         dv_q_ff[0]       <= '0;
      end
   end

   for (genvar k = 0; k < ANGLE_W; k++) begin : g_phi_div
      logic [REM_W:0]   dbl_in;
      logic             bit_in;
      logic [REM_W-1:0] rem_in;

      always_comb begin
         dbl_in = {dv_rem_ff[k], 1'b0};
         bit_in = dbl_in >= (REM_W+1)'(cf_n_ff);
         rem_in = bit_in ? REM_W'(dbl_in - (REM_W+1)'(cf_n_ff)) : REM_W'(dbl_in);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_tag_ff[k+1].valid <= 1'b0;
         end else if (en) begin
            dv_tag_ff[k+1].valid <= dv_tag_ff[k].valid;
         end
         if (en) begin
            dv_tag_ff[k+1].err <= dv_tag_ff[k].err;
            dv_rem_ff[k+1]     <= rem_in;
            dv_q_ff[k+1]       <= {dv_q_ff[k][ANGLE_W-2:0], bit_in};
         end
      end
   end

   // ------------------------------------------------------------------
   // Sine and cosine of phi and of the rotation angle, side by side.
   // ------------------------------------------------------------------
   logic signed [TRIG_W-1:0] phi_cos;
   logic signed [TRIG_W-1:0] phi_sin;
   logic signed [TRIG_W-1:0] rot_cos;
   logic signed [TRIG_W-1:0] rot_sin;
   epg_pkg::tag_type         ct_tag_ff [0:CL-1];

   epg_cordic #(
      .STAGES (CORDIC_STAGES)
   ) u_phi_cordic (
      .clock   (clock),
      .enable  (en),
      .angle   (dv_q_ff[ANGLE_W]),
      .cos_out (phi_cos),
      .sin_out (phi_sin)
   );

   epg_cordic #(
      .STAGES (CORDIC_STAGES)
   ) u_rot_cordic (
      .clock   (clock),
      .enable  (en),
      .angle   (cfg_rot_ff),
      .cos_out (rot_cos),
      .sin_out (rot_sin)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ct_tag_ff[0].valid <= 1'b0;
      end else if (en) begin
         ct_tag_ff[0].valid <= dv_tag_ff[ANGLE_W].valid;
      end
      if (en) begin
         ct_tag_ff[0].err <= dv_tag_ff[ANGLE_W].err;
      end
   end

   for (genvar k = 1; k < CL; k++) begin : g_cordic_tag
      always_ff @(posedge clock) begin
         if (reset) begin
            ct_tag_ff[k].valid <= 1'b0;
         end else if (en) begin
            ct_tag_ff[k].valid <= ct_tag_ff[k-1].valid;
         end
         if (en) begin
            ct_tag_ff[k].err <= ct_tag_ff[k-1].err;
         end
      end
   end

   // ------------------------------------------------------------------
   // Radicand D = (B^2 << 24) + (A^2 - B^2) * sin^2, in Q24. The wide
   // product is split into two 18-bit halves.
   // ------------------------------------------------------------------
   logic signed [2*TRIG_W-1:0] s_sq_in;
   epg_pkg::trig_type          trig_in;
   epg_pkg::tag_type           m1_tag_ff;
   epg_pkg::trig_type          m1_trig_ff;
   logic [S2_W-1:0]            m1_s2_ff;
   epg_pkg::tag_type           m2_tag_ff;
   epg_pkg::trig_type          m2_trig_ff;
   logic [AXIS_W+S2_W-1:0]     m2_lo_ff;
   logic [AXIS_W+S2_W-1:0]     m2_hi_ff;

   always_comb begin
      s_sq_in    = phi_sin * phi_sin;
      trig_in.c  = phi_cos;
      trig_in.s  = phi_sin;
      trig_in.ca = rot_cos;
      trig_in.sa = rot_sin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_tag_ff.valid <= 1'b0;
         m2_tag_ff.valid <= 1'b0;
      end else if (en) begin
         m1_tag_ff.valid <= ct_tag_ff[CL-1].valid;
         m2_tag_ff.valid <= m1_tag_ff.valid;
      end
      if (en) begin
         m1_tag_ff.err <= ct_tag_ff[CL-1].err;
         m1_trig_ff    <= trig_in;
         m1_s2_ff      <= s_sq_in[24+S2_W-1:24];
         m2_tag_ff.err <= m1_tag_ff.err;
         m2_trig_ff    <= m1_trig_ff;
         m2_lo_ff      <= cf_dif_ff[AXIS_W-1:0] * m1_s2_ff;
         m2_hi_ff      <= cf_dif_ff[2*AXIS_W-1:AXIS_W] * m1_s2_ff;
      end
   end

   // ------------------------------------------------------------------
   // Square root, digit by digit, one result bit per stage. Stage zero
   // holds the radicand.
   // ------------------------------------------------------------------
   epg_pkg::tag_type  sq_tag_ff  [0:SQ_N];
   epg_pkg::trig_type sq_trig_ff [0:SQ_N];
   logic [SQ_W-1:0]   sq_v_ff    [0:SQ_N];
   logic [SQ_W-1:0]   sq_res_ff  [0:SQ_N];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_tag_ff[0].valid <= 1'b0;
      end else if (en) begin
         sq_tag_ff[0].valid <= m2_tag_ff.valid;
      end
      if (en) begin
         sq_tag_ff[0].err <= m2_tag_ff.err;
         sq_trig_ff[0]    <= m2_trig_ff;
         sq_v_ff[0]       <= (SQ_W'(cf_bsq_ff) << 24) + SQ_W'(m2_lo_ff)
                             + (SQ_W'(m2_hi_ff) << AXIS_W);
         sq_res_ff[0]     <= '0;
      end
   end

   for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
      localparam logic [SQ_W-1:0] BIT_K = SQ_W'(1) << (SQ_W - 2 - 2 * k);
      logic [SQ_W-1:0] trial_in;
      logic            take_in;

      always_comb begin
         trial_in = sq_res_ff[k] + BIT_K;
         take_in  = sq_v_ff[k] >= trial_in;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_tag_ff[k+1].valid <= 1'b0;
         end else if (en) begin
            sq_tag_ff[k+1].valid <= sq_tag_ff[k].valid;
         end
         if (en) begin
            sq_tag_ff[k+1].err <= sq_tag_ff[k].err;
            sq_trig_ff[k+1]    <= sq_trig_ff[k];
            sq_v_ff[k+1]       <= take_in ? (sq_v_ff[k] - trial_in) : sq_v_ff[k];
            sq_res_ff[k+1]     <= take_in ? ((sq_res_ff[k] >> 1) + BIT_K)
                                          : (sq_res_ff[k] >> 1);
         end
      end
   end

   // ------------------------------------------------------------------
   // Radius r = round((a*b << (FRAC_BITS + 12)) / S), restoring division
   // with one quotient bit per stage. Stage zero forms the dividend.
   // ------------------------------------------------------------------
   logic [ROOT_W-1:0] root_in;
   logic [DVD_W-1:0]  dividend_in;

   epg_pkg::tag_type  dd_tag_ff  [0:RQ];
   epg_pkg::trig_type dd_trig_ff [0:RQ];
   logic [DR_W-1:0]   dd_rem_ff  [0:RQ];
   logic [RQ-1:0]     dd_low_ff  [0:RQ];
   logic [ROOT_W-1:0] dd_root_ff [0:RQ];
   logic [RQ-1:0]     dd_q_ff    [0:RQ];

   always_comb begin
      root_in     = sq_res_ff[SQ_N][ROOT_W-1:0];
      dividend_in = (DVD_W'(cf_ab_ff) << (FRAC_BITS + 12)) + DVD_W'(root_in >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dd_tag_ff[0].valid <= 1'b0;
      end else if (en) begin
         dd_tag_ff[0].valid <= sq_tag_ff[SQ_N].valid;
      end
      if (en) begin
         dd_tag_ff[0].err <= sq_tag_ff[SQ_N].err;
         dd_trig_ff[0]    <= sq_trig_ff[SQ_N];
         dd_rem_ff[0]     <= DR_W'(dividend_in >> RQ);
         dd_low_ff[0]     <= dividend_in[RQ-1:0];
         dd_root_ff[0]    <= root_in;
         dd_q_ff[0]       <= '0;
      end
   end

   for (genvar k = 0; k < RQ; k++) begin : g_rdiv
      logic [DR_W:0]   dbl_in;
      logic            bit_in;

      always_comb begin
         dbl_in = {dd_rem_ff[k], dd_low_ff[k][RQ-1]};
         bit_in = dbl_in >= (DR_W+1)'(dd_root_ff[k]);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dd_tag_ff[k+1].valid <= 1'b0;
         end else if (en) begin
            dd_tag_ff[k+1].valid <= dd_tag_ff[k].valid;
         end
         if (en) begin
            dd_tag_ff[k+1].err <= dd_tag_ff[k].err;
            dd_trig_ff[k+1]    <= dd_trig_ff[k];
            dd_rem_ff[k+1]     <= bit_in ? DR_W'(dbl_in - (DR_W+1)'(dd_root_ff[k]))
                                         : DR_W'(dbl_in);
            dd_low_ff[k+1]     <= dd_low_ff[k] << 1;
            dd_root_ff[k+1]    <= dd_root_ff[k];
            dd_q_ff[k+1]       <= {dd_q_ff[k][RQ-2:0], bit_in};
         end
      end
   end

   // ------------------------------------------------------------------
   // Point on the unrotated ellipse, rotation and center offset.
   // ------------------------------------------------------------------
   logic [RQ-1:0]            radius_in;
   logic signed [PC_W-1:0]   rc_in;
   logic signed [PC_W-1:0]   rs_in;

   epg_pkg::tag_type         p1_tag_ff;
   logic signed [XW-1:0]     p1_xr_ff;
   logic signed [XW-1:0]     p1_yr_ff;
   logic signed [TRIG_W-1:0] p1_ca_ff;
   logic signed [TRIG_W-1:0] p1_sa_ff;

   // A zero semi-axis can leave the divisor at zero, so the radius is forced to zero; the point is then the center.
   always_comb begin
      radius_in = cf_zero_ff ? '0 : dd_q_ff[RQ];
      rc_in = ($signed({1'b0, radius_in}) * dd_trig_ff[RQ].c)
              + $signed(PC_W'(24'h80_0000));
      rs_in = ($signed({1'b0, radius_in}) * dd_trig_ff[RQ].s)
              + $signed(PC_W'(24'h80_0000));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_tag_ff.valid <= 1'b0;
      end else if (en) begin
         p1_tag_ff.valid <= dd_tag_ff[RQ].valid;
      end
      if (en) begin
         p1_tag_ff.err <= dd_tag_ff[RQ].err;
         p1_xr_ff      <= XW'(rc_in >>> 24);
         p1_yr_ff      <= XW'(rs_in >>> 24);
         p1_ca_ff      <= dd_trig_ff[RQ].ca;
         p1_sa_ff      <= dd_trig_ff[RQ].sa;
      end
   end

   epg_pkg::tag_type     p2_tag_ff;
   logic signed [PW-1:0] p2_xc_ff;
   logic signed [PW-1:0] p2_ys_ff;
   logic signed [PW-1:0] p2_xs_ff;
   logic signed [PW-1:0] p2_yc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_tag_ff.valid <= 1'b0;
      end else if (en) begin
         p2_tag_ff.valid <= p1_tag_ff.valid;
      end
      if (en) begin
         p2_tag_ff.err <= p1_tag_ff.err;
         p2_xc_ff      <= p1_xr_ff * p1_ca_ff;
         p2_ys_ff      <= p1_yr_ff * p1_sa_ff;
         p2_xs_ff      <= p1_xr_ff * p1_sa_ff;
         p2_yc_ff      <= p1_yr_ff * p1_ca_ff;
      end
   end

   logic signed [PW:0]   sum_x_in;
   logic signed [PW:0]   sum_y_in;
   epg_pkg::tag_type     p3_tag_ff;
   logic signed [RW-1:0] p3_rx_ff;
   logic signed [RW-1:0] p3_ry_ff;

   always_comb begin
      sum_x_in = (PW+1)'(p2_xc_ff) - (PW+1)'(p2_ys_ff) + $signed((PW+1)'(24'h80_0000));
      sum_y_in = (PW+1)'(p2_xs_ff) + (PW+1)'(p2_yc_ff) + $signed((PW+1)'(24'h80_0000));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_tag_ff.valid <= 1'b0;
      end else if (en) begin
         p3_tag_ff.valid <= p2_tag_ff.valid;
      end
      if (en) begin
         p3_tag_ff.err <= p2_tag_ff.err;
         p3_rx_ff      <= RW'(sum_x_in >>> 24);
         p3_ry_ff      <= RW'(sum_y_in >>> 24);
      end
   end

   // ------------------------------------------------------------------
   // Center offset and saturation into the output register. An index
   // error word carries a zero point.
   // ------------------------------------------------------------------
   logic signed [SW-1:0]    xo_in;
   logic signed [SW-1:0]    yo_in;
   logic signed [OUT_W-1:0] x_sat_in;
   logic signed [OUT_W-1:0] y_sat_in;
   logic                    hit_in;

   logic signed [OUT_W-1:0] rsp_x_ff;
   logic signed [OUT_W-1:0] rsp_y_ff;
   logic                    rsp_err_ff;
   logic                    rsp_sat_ff;

   always_comb begin
      xo_in  = SW'(p3_rx_ff) + SW'(cfg_cx_ff);
      yo_in  = SW'(p3_ry_ff) + SW'(cfg_cy_ff);
      hit_in = 1'b0;
      if (xo_in > OUT_HI) begin
         x_sat_in = OUT_W'(OUT_HI);
         hit_in   = 1'b1;
      end else if (xo_in < OUT_LO) begin
         x_sat_in = OUT_W'(OUT_LO);
         hit_in   = 1'b1;
      end else begin
         x_sat_in = OUT_W'(xo_in);
      end
      if (yo_in > OUT_HI) begin
         y_sat_in = OUT_W'(OUT_HI);
         hit_in   = 1'b1;
      end else if (yo_in < OUT_LO) begin
         y_sat_in = OUT_W'(OUT_LO);
         hit_in   = 1'b1;
      end else begin
         y_sat_in = OUT_W'(yo_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= p3_tag_ff.valid;
      end
      if (en) begin
         rsp_err_ff <= p3_tag_ff.err;
         if (p3_tag_ff.err) begin
            rsp_x_ff   <= '0;
            rsp_y_ff   <= '0;
            rsp_sat_ff <= 1'b0;
         end else begin
            rsp_x_ff   <= x_sat_in;
            rsp_y_ff   <= y_sat_in;
            rsp_sat_ff <= hit_in;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_x     = rsp_x_ff;
   assign rsp_point_y     = rsp_y_ff;
   assign rsp_index_error = rsp_err_ff;
   assign rsp_saturated   = rsp_sat_ff;

endmodule

`default_nettype wire
